// ----- rtl/tree_path_max_query_defines.svh -----
// Assertion macros for the path-maximum engine.
`ifndef TREE_PATH_MAX_QUERY_DEFINES_SVH
`define TREE_PATH_MAX_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define TPMQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define TPMQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tpmq_pkg.sv -----
`timescale 1ns / 1ps

package tpmq_pkg;

    localparam int NODE_BITS   = 10;
    localparam int MAX_NODES   = 1024;
    localparam int LEVELS      = 10;
    localparam int WEIGHT_BITS = 48;
    localparam int DEPTH_BITS  = LEVELS;
    localparam int LVL_BITS    = $clog2(LEVELS);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [NODE_BITS-1:0]   node_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [DEPTH_BITS-1:0]  depth_t;
    typedef logic [LVL_BITS-1:0]    lvl_t;

    typedef struct packed {
        depth_t                     depth;
        logic [LEVELS-1:0][NODE_BITS-1:0]   anc;
        logic [LEVELS-1:0][WEIGHT_BITS-1:0] mx;
    } row_t;

    function automatic weight_t wmax(weight_t a, weight_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/tree_path_max_query.sv -----
// Add: one row read per level on port A.
// Query: both rows load, then the deeper node is lifted level by level; if the nodes
// still differ, both are jumped up together, and a final step adds the last edges.
// Each lift or jump step that is taken waits for its row read, one step per read.
// One item at a time; a result not yet taken holds its query in the output state.
// Reset (aresetn low, synchronous) clears control, then a clearing pass writes
// zero to all 1024 rows with s_ready low.
`timescale 1ns / 1ps
`include "tree_path_max_query_defines.svh"

module tree_path_max_query (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  tpmq_pkg::node_t      s_node_a,
    input  tpmq_pkg::node_t      s_node_b,
    input  tpmq_pkg::weight_t    s_edge_weight,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tpmq_pkg::weight_t    m_path_max
);

    import tpmq_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_BASE,
        ST_ADD_LVL,
        ST_Q_LOAD,
        ST_Q_LIFT,
        ST_Q_LIFT_WAIT,
        ST_Q_CHECK,
        ST_Q_JUMP,
        ST_Q_JUMP_WAIT,
        ST_Q_FINAL,
        ST_Q_OUT
    } state_t;

    row_t mem [MAX_NODES];
    row_t rd_a_reg;
    row_t rd_b_reg;

    state_t  state_reg,      state_next;
    lvl_t    lvl_reg,        lvl_next;
    node_t   clr_addr_reg,   clr_addr_next;
    node_t   a_node_reg,     a_node_next;
    node_t   b_node_reg,     b_node_next;
    row_t    a_row_reg,      a_row_next;
    row_t    b_row_reg,      b_row_next;
    weight_t acc_reg,        acc_next;
    logic    m_valid_reg,    m_valid_next;
    weight_t m_path_max_reg, m_path_max_next;

    logic    wr_en;
    node_t   wr_addr;
    row_t    wr_data;
    node_t   rd_a_addr;
    node_t   rd_b_addr;

    lvl_t                lvl_prev;
    row_t                fwd_row;
    node_t               new_anc;
    logic [DEPTH_BITS:0] lift_diff;
    logic                lift_take;
    logic                s_accept;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_path_max = m_path_max_reg;

    assign lvl_prev  = lvl_reg - 1'b1;
    assign fwd_row   = (a_row_reg.anc[lvl_prev] == a_node_reg) ? a_row_reg : rd_a_reg;
    assign new_anc   = fwd_row.anc[lvl_prev];
    assign lift_diff = {1'b0, a_row_reg.depth} - {1'b0, b_row_reg.depth};
    assign lift_take = !lift_diff[DEPTH_BITS]
                       && (lift_diff[DEPTH_BITS-1:0] >= (depth_t'(1) << lvl_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb begin
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        clr_addr_next   = clr_addr_reg;
        a_node_next     = a_node_reg;
        b_node_next     = b_node_reg;
        a_row_next      = a_row_reg;
        b_row_next      = b_row_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_path_max_next = m_path_max_reg;
        wr_en           = 1'b0;
        wr_addr         = a_node_reg;
        wr_data         = a_row_reg;
        rd_a_addr       = s_node_a;
        rd_b_addr       = s_node_b;

        case (state_reg)
            ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == node_t'(MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rd_a_addr = s_node_a;
                rd_b_addr = s_node_b;
                if (s_accept) begin
                    a_node_next = s_node_a;
                    b_node_next = s_node_b;
                    acc_next    = s_edge_weight;
                    if (s_opcode == OP_QUERY) begin
                        state_next = ST_Q_LOAD;
                    end else if (s_node_a != '0) begin
                        rd_a_addr  = s_node_b;
                        state_next = ST_ADD_BASE;
                    end
                end
            end
            ST_ADD_BASE: begin
                a_row_next       = rd_a_reg;
                a_row_next.depth = rd_a_reg.depth + 1'b1;
                a_row_next.anc[0] = b_node_reg;
                a_row_next.mx[0]  = acc_reg;
                lvl_next         = lvl_t'(1);
                rd_a_addr        = b_node_reg;
                state_next       = ST_ADD_LVL;
            end
            ST_ADD_LVL: begin
                a_row_next.anc[lvl_reg] = new_anc;
                a_row_next.mx[lvl_reg]  = wmax(a_row_reg.mx[lvl_prev], fwd_row.mx[lvl_prev]);
                rd_a_addr = new_anc;
                if (lvl_reg == lvl_t'(LEVELS - 1)) begin
                    wr_en      = 1'b1;
                    wr_addr    = a_node_reg;
                    wr_data    = a_row_next;
                    state_next = ST_IDLE;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_Q_LOAD: begin
                if (rd_a_reg.depth < rd_b_reg.depth) begin
                    a_node_next = b_node_reg;
                    b_node_next = a_node_reg;
                    a_row_next  = rd_b_reg;
                    b_row_next  = rd_a_reg;
                end else begin
                    a_row_next = rd_a_reg;
                    b_row_next = rd_b_reg;
                end
                acc_next   = '0;
                lvl_next   = lvl_t'(LEVELS - 1);
                state_next = ST_Q_LIFT;
            end
            ST_Q_LIFT: begin
                rd_a_addr = a_row_reg.anc[lvl_reg];
                if (lift_take) begin
                    acc_next    = wmax(acc_reg, a_row_reg.mx[lvl_reg]);
                    a_node_next = a_row_reg.anc[lvl_reg];
                    state_next  = ST_Q_LIFT_WAIT;
                end else if (lvl_reg == '0) begin
                    state_next = ST_Q_CHECK;
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_Q_LIFT_WAIT: begin
                a_row_next = rd_a_reg;
                if (lvl_reg == '0) begin
                    state_next = ST_Q_CHECK;
                end else begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_Q_LIFT;
                end
            end
            ST_Q_CHECK: begin
                lvl_next = lvl_t'(LEVELS - 1);
                if (a_node_reg == b_node_reg) begin
                    state_next = ST_Q_OUT;
                end else begin
                    state_next = ST_Q_JUMP;
                end
            end
            ST_Q_JUMP: begin
                rd_a_addr = a_row_reg.anc[lvl_reg];
                rd_b_addr = b_row_reg.anc[lvl_reg];
                if (a_row_reg.anc[lvl_reg] != b_row_reg.anc[lvl_reg]) begin
                    acc_next    = wmax(acc_reg,
                                       wmax(a_row_reg.mx[lvl_reg], b_row_reg.mx[lvl_reg]));
                    a_node_next = a_row_reg.anc[lvl_reg];
                    b_node_next = b_row_reg.anc[lvl_reg];
                    state_next  = ST_Q_JUMP_WAIT;
                end else if (lvl_reg == '0) begin
                    state_next = ST_Q_FINAL;
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_Q_JUMP_WAIT: begin
                a_row_next = rd_a_reg;
                b_row_next = rd_b_reg;
                if (lvl_reg == '0) begin
                    state_next = ST_Q_FINAL;
                end else begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_Q_JUMP;
                end
            end
            ST_Q_FINAL: begin
                acc_next   = wmax(acc_reg, wmax(a_row_reg.mx[0], b_row_reg.mx[0]));
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_path_max_next = acc_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            lvl_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            lvl_reg      <= lvl_next;
            m_valid_reg  <= m_valid_next;
        end
        a_node_reg     <= a_node_next;
        b_node_reg     <= b_node_next;
        a_row_reg      <= a_row_next;
        b_row_reg      <= b_row_next;
        acc_reg        <= acc_next;
        m_path_max_reg <= m_path_max_next;
    end

    `TPMQ_ASSERT_IMP(a_no_accept_in_clear, state_reg == ST_CLEAR, !s_ready,
        "transaction accepted during clear")
    `TPMQ_ASSERT_IMP(a_write_source, wr_en,
        (state_reg == ST_CLEAR) || (state_reg == ST_ADD_LVL),
        "row write outside clear or add")
    `TPMQ_ASSERT_IMP(a_no_sentinel_write, wr_en && (state_reg == ST_ADD_LVL),
        a_node_reg != '0, "sentinel row overwritten")
    `TPMQ_ASSERT_NXT(a_query_start, s_valid && s_ready && (s_opcode == OP_QUERY),
        state_reg == ST_Q_LOAD, "query transaction not started")
    `TPMQ_ASSERT_NXT(a_result_hold, (state_reg == ST_Q_OUT) && m_valid_reg && !m_ready,
        state_reg == ST_Q_OUT, "pending result dropped")

endmodule
